### sv/rau_pkg.sv
// Shared types and op codes for the rational arithmetic unit.
// No dependencies; imported by the top level and its checker.
`default_nettype none
package rau_pkg;

	localparam int FIELD_W   = 32;
	localparam int WIDTH_DEF = 32;
	localparam int OP_W      = 3;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_NORM = 3'd0;
	localparam op_t OP_ADD  = 3'd1;
	localparam op_t OP_SUB  = 3'd2;
	localparam op_t OP_MUL  = 3'd3;
	localparam op_t OP_DIV  = 3'd4;
	localparam op_t OP_EQ   = 3'd5;
	localparam op_t OP_LT   = 3'd6;
	localparam op_t OP_GT   = 3'd7;

	typedef struct packed {
		op_t                       op;
		logic signed [FIELD_W-1:0] a_num;
		logic signed [FIELD_W-1:0] a_den;
		logic signed [FIELD_W-1:0] b_num;
		logic signed [FIELD_W-1:0] b_den;
	} in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] res_num;
		logic signed [FIELD_W-1:0] res_den;
		logic                      cmp_true;
		logic                      overflow;
	} out_t;

endpackage
`default_nettype wire

### sv/rational_arithmetic_unit.sv
// Latency from accepted start to done is data dependent. It is set by
// rau_reduce, run up to three times (operand a, operand b, result) at one
// gcd step and one quotient bit per cycle, plus a shift-add multiply.
// One word in flight; start is taken again in the cycle done shows.
// Reset (arst_n low) clears control only; result holds until the next done.
// Depends on rau_pkg and rau_reduce.
`default_nettype none
module rational_arithmetic_unit #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rau_pkg::in_t  cmd,
	output logic          done,
	output rau_pkg::out_t result
);

	import rau_pkg::*;

	localparam int RW = 2 * WIDTH;
	localparam int CW = $clog2(WIDTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NCHK  = 3'd1;
	localparam logic [2:0] ST_NWAIT = 3'd2;
	localparam logic [2:0] ST_NEND  = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_COMB  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_R = 2'd2;

	// {sign, magnitude} of the low WIDTH bits read as signed
	function automatic logic [WIDTH:0] sm_in(logic [FIELD_W-1:0] raw);
		logic [WIDTH-1:0] x;
		logic             neg;
		x   = raw[WIDTH-1:0];
		neg = x[WIDTH-1];
		return {neg, neg ? (~x + 1'b1) : x};
	endfunction

	function automatic logic [RW-1:0] mstep(logic [RW-1:0] acc, logic [WIDTH-1:0] mc);
		logic [WIDTH:0] hi;
		hi = {1'b0, acc[RW-1:WIDTH]};
		if (acc[0]) hi = hi + {1'b0, mc};
		return {hi, acc[WIDTH-1:1]};
	endfunction

	function automatic logic fits(logic neg, logic [RW-1:0] mag);
		logic [WIDTH:0] top;
		top = mag[RW-1:WIDTH-1];
		return (top == '0) ||
			(neg && top == (WIDTH+1)'(1) && mag[WIDTH-2:0] == '0);
	endfunction

	function automatic logic [FIELD_W-1:0] sm_out(logic neg, logic [RW-1:0] mag);
		logic [WIDTH-1:0] x;
		x = neg ? (~mag[WIDTH-1:0] + 1'b1) : mag[WIDTH-1:0];
		return FIELD_W'(signed'(x));
	endfunction

	function automatic logic sm_lt(logic sx, logic [RW-1:0] x, logic sy, logic [RW-1:0] y);
		if (sx != sy) return sx;
		if (!sx) return x < y;
		return x > y;
	endfunction

	logic [2:0]       state_q;
	logic [1:0]       phase_q;
	op_t              op_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	out_t             result_q;

	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic             ann_q, bnn_q, bdn_q;
	logic [RW-1:0]    wn_q, wd_q;
	logic             wnn_q, wdn_q;
	logic [RW-1:0]    acc0_q, acc1_q, acc2_q;
	logic [WIDTH-1:0] mc0_q, mc1_q, mc2_q;
	logic             ps0_q, ps1_q;

	logic             red_start, red_done;
	logic [RW-1:0]    red_num, red_den;

	logic [WIDTH:0]   an_in, ad_in, bn_in, bd_in;
	logic             w_nz_n, w_nz_d, is_cmp_op;
	logic             nz0, nz1, s0, s1, sy, ge01;
	logic [RW-1:0]    sum01, d01, d10, add_mag;
	logic             add_neg;
	logic [RW-1:0]    r_num_mag, r_den_mag;
	logic             r_num_neg, r_den_neg, cmp_res;
	out_t             out_w, out_c;

	rau_reduce #(
		.RW(RW)
	) u_reduce (
		.clk   (clk),
		.arst_n(arst_n),
		.start (red_start),
		.num   (wn_q),
		.den   (wd_q),
		.done  (red_done),
		.q_num (red_num),
		.q_den (red_den)
	);

	always_comb begin
		an_in     = sm_in(cmd.a_num);
		ad_in     = sm_in(cmd.a_den);
		bn_in     = sm_in(cmd.b_num);
		bd_in     = sm_in(cmd.b_den);
		w_nz_n    = wn_q != '0;
		w_nz_d    = wd_q != '0;
		red_start = (state_q == ST_NCHK) && w_nz_n && w_nz_d;
		is_cmp_op = op_q inside {OP_EQ, OP_LT, OP_GT};

		// product signs, zero magnitudes forced positive
		nz0   = acc0_q != '0;
		nz1   = acc1_q != '0;
		s0    = ps0_q & nz0;
		s1    = ps1_q & nz1;
		sy    = (op_q == OP_SUB) ? (~ps1_q & nz1) : s1;
		sum01 = acc0_q + acc1_q;
		d01   = acc0_q - acc1_q;
		d10   = acc1_q - acc0_q;
		ge01  = acc0_q >= acc1_q;

		if (s0 == sy) begin
			add_neg = s0;
			add_mag = sum01;
		end else if (ge01) begin
			add_neg = s0;
			add_mag = d01;
		end else begin
			add_neg = sy;
			add_mag = d10;
		end
		add_neg = add_neg && (add_mag != '0);

		if (op_q == OP_ADD || op_q == OP_SUB) begin
			r_num_neg = add_neg;
			r_num_mag = add_mag;
		end else begin
			r_num_neg = s0;
			r_num_mag = acc0_q;
		end
		if (op_q == OP_DIV) begin
			r_den_neg = s1;
			r_den_mag = acc1_q;
		end else begin
			r_den_neg = 1'b0;
			r_den_mag = acc2_q;
		end

		case (op_q)
			OP_EQ:   cmp_res = (ann_q == bnn_q) && (an_q == bn_q) && (ad_q == bd_q);
			OP_LT:   cmp_res = sm_lt(s0, acc0_q, s1, acc1_q);
			OP_GT:   cmp_res = sm_lt(s1, acc1_q, s0, acc0_q);
			default: cmp_res = 1'b0;
		endcase

		out_c.res_num  = '0;
		out_c.res_den  = '0;
		out_c.cmp_true = cmp_res;
		out_c.overflow = 1'b0;

		out_w.res_num  = sm_out(wnn_q, wn_q);
		out_w.res_den  = sm_out(1'b0, wd_q);
		out_w.cmp_true = 1'b0;
		out_w.overflow = !(fits(wnn_q, wn_q) && fits(1'b0, wd_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_A;
			op_q    <= OP_NORM;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_NCHK;
						phase_q <= PH_A;
						op_q    <= cmd.op;
					end
				end
				ST_NCHK: begin
					state_q <= red_start ? ST_NWAIT : ST_NEND;
				end
				ST_NWAIT: begin
					if (red_done) state_q <= ST_NEND;
				end
				ST_NEND: begin
					case (phase_q)
						PH_A: begin
							if (op_q == OP_NORM) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_NCHK;
								phase_q <= PH_B;
							end
						end
						PH_B: begin
							if (op_q == OP_EQ) begin
								state_q <= ST_COMB;
							end else begin
								state_q <= ST_MUL;
								cnt_q   <= CW'(WIDTH-1);
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_MUL: begin
					if (cnt_q == '0) state_q <= ST_COMB;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_COMB: begin
					if (is_cmp_op) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_NCHK;
						phase_q <= PH_R;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					wnn_q <= an_in[WIDTH];
					wn_q  <= RW'(an_in[WIDTH-1:0]);
					wdn_q <= ad_in[WIDTH];
					wd_q  <= RW'(ad_in[WIDTH-1:0]);
					bnn_q <= bn_in[WIDTH];
					bn_q  <= bn_in[WIDTH-1:0];
					bdn_q <= bd_in[WIDTH];
					bd_q  <= bd_in[WIDTH-1:0];
				end
			end
			ST_NCHK: begin
				// zero numerator: 0/1; zero denominator: left untouched
				if (!w_nz_n) begin
					wnn_q <= 1'b0;
					wdn_q <= 1'b0;
					wd_q  <= RW'(1);
				end else if (w_nz_d) begin
					wnn_q <= wnn_q ^ wdn_q;
					wdn_q <= 1'b0;
				end
			end
			ST_NWAIT: begin
				if (red_done) begin
					wn_q <= red_num;
					wd_q <= red_den;
				end
			end
			ST_NEND: begin
				case (phase_q)
					PH_A: begin
						an_q  <= wn_q[WIDTH-1:0];
						ad_q  <= wd_q[WIDTH-1:0];
						ann_q <= wnn_q;
						if (op_q != OP_NORM) begin
							wn_q  <= RW'(bn_q);
							wd_q  <= RW'(bd_q);
							wnn_q <= bnn_q;
							wdn_q <= bdn_q;
						end
					end
					PH_B: begin
						bn_q  <= wn_q[WIDTH-1:0];
						bd_q  <= wd_q[WIDTH-1:0];
						bnn_q <= wnn_q;
						// lane 0: a.num * (b.num for mul, else b.den)
						// lane 1: a.den * b.num, lane 2: a.den * b.den
						mc0_q  <= an_q;
						acc0_q <= RW'((op_q == OP_MUL) ? wn_q[WIDTH-1:0] : wd_q[WIDTH-1:0]);
						ps0_q  <= ann_q ^ ((op_q == OP_MUL) && wnn_q);
						mc1_q  <= ad_q;
						acc1_q <= RW'(wn_q[WIDTH-1:0]);
						ps1_q  <= wnn_q;
						mc2_q  <= ad_q;
						acc2_q <= RW'(wd_q[WIDTH-1:0]);
					end
					default: ;
				endcase
			end
			ST_MUL: begin
				acc0_q <= mstep(acc0_q, mc0_q);
				acc1_q <= mstep(acc1_q, mc1_q);
				acc2_q <= mstep(acc2_q, mc2_q);
			end
			ST_COMB: begin
				if (is_cmp_op) begin
					result_q <= out_c;
				end else begin
					wn_q  <= r_num_mag;
					wnn_q <= r_num_neg;
					wd_q  <= r_den_mag;
					wdn_q <= r_den_neg;
				end
			end
			ST_DONE: begin
				result_q <= out_w;
			end
			default: ;
		endcase
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

### sv/rau_reduce.sv
// Fraction reduction: binary gcd of two magnitudes, one step per cycle,
// then both divided by the gcd with a bit-serial restoring divider.
// Standalone; instantiated by rational_arithmetic_unit.
`default_nettype none
module rau_reduce #(
	parameter int RW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RW-1:0] num,
	input  logic [RW-1:0] den,
	output logic          done,
	output logic [RW-1:0] q_num,
	output logic [RW-1:0] q_den
);

	localparam int CW = $clog2(RW);
	localparam logic [1:0] RS_IDLE = 2'd0;
	localparam logic [1:0] RS_GCD  = 2'd1;
	localparam logic [1:0] RS_DIV  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [RW-1:0] u_q, v_q, n_q, d_q, rn_q, rd_q;

	logic [RW:0]   tn, td, sub_n, sub_d;
	logic          ge_n, ge_d;
	logic [RW-1:0] u_m_v, v_m_u;
	logic          u_gt_v, u_eq_v;

	always_comb begin
		tn     = {rn_q, n_q[RW-1]};
		td     = {rd_q, d_q[RW-1]};
		sub_n  = tn - {1'b0, u_q};
		sub_d  = td - {1'b0, u_q};
		ge_n   = tn >= {1'b0, u_q};
		ge_d   = td >= {1'b0, u_q};
		u_m_v  = u_q - v_q;
		v_m_u  = v_q - u_q;
		u_gt_v = u_q > v_q;
		u_eq_v = u_q == v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				RS_IDLE: begin
					if (start) state_q <= RS_GCD;
				end
				RS_GCD: begin
					// both odd and equal: u holds the odd part of the gcd
					if (u_q[0] && v_q[0] && u_eq_v) begin
						if (u_q == RW'(1)) begin
							state_q <= RS_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= RS_DIV;
							cnt_q   <= CW'(RW-1);
						end
					end
				end
				RS_DIV: begin
					if (cnt_q == '0) begin
						state_q <= RS_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= RS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			RS_IDLE: begin
				if (start) begin
					u_q <= num;
					v_q <= den;
					n_q <= num;
					d_q <= den;
				end
			end
			RS_GCD: begin
				if (!u_q[0] && !v_q[0]) begin
					// common factor of two comes straight off the operands
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					n_q <= n_q >> 1;
					d_q <= d_q >> 1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_gt_v) begin
					u_q <= u_m_v >> 1;
				end else if (!u_eq_v) begin
					v_q <= v_m_u >> 1;
				end else begin
					rn_q <= '0;
					rd_q <= '0;
				end
			end
			RS_DIV: begin
				n_q  <= {n_q[RW-2:0], ge_n};
				d_q  <= {d_q[RW-2:0], ge_d};
				rn_q <= ge_n ? sub_n[RW-1:0] : tn[RW-1:0];
				rd_q <= ge_d ? sub_d[RW-1:0] : td[RW-1:0];
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign q_num = n_q;
	assign q_den = d_q;

endmodule
`default_nettype wire

### sv/rau_check.sv
// Port-level checks for rational_arithmetic_unit, bound to the top level.
// Depends on rau_pkg.
`default_nettype none
module rau_check (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire rau_pkg::out_t result
);

	import rau_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result word");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.cmp_true |->
			result.res_num == '0 && result.res_den == '0 && !result.overflow)
		else $error("comparison word carries fraction fields");

endmodule

bind rational_arithmetic_unit rau_check u_rau_check (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
`default_nettype wire
